// ===== rtl/core/cvq_pkg.sv =====
`default_nettype none
package cvq_pkg;
  localparam int NumUnits  = 16;
  localparam int VectorLen = 16;
  localparam int UnitW     = 4;
  localparam int PosW      = 4;
  localparam int AddrW     = UnitW + PosW;
  localparam int SumW      = 38;
  localparam int DistW     = 18;
  localparam int CntW      = 5;

  localparam logic [1:0] CMD_LOAD     = 2'd0;
  localparam logic [1:0] CMD_TRAIN    = 2'd1;
  localparam logic [1:0] CMD_CLASSIFY = 2'd2;

  localparam logic [1:0] REG_RATE  = 2'd0;
  localparam logic [1:0] REG_ITER  = 2'd1;
  localparam logic [1:0] REG_UNITS = 2'd2;

  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,     // write weight
    OP_CAPT,     // latch pattern element value
    OP_ACC_RD,   // read weight for unit
    OP_ACC_ADD,  // add square into sum of unit
    OP_SRCH,     // compare sum of unit against current best
    OP_SQ_INIT,  // start isqrt of sum of unit
    OP_SQ_STEP,  // one isqrt step
    OP_EMIT,     // drive result
    OP_TR_RD,    // read winner weight at pos
    OP_TR_MUL,   // product
    OP_TR_WR,    // round, saturate, write back
    OP_CLEAR,    // clear sums
    OP_FACT_MUL, // rate * (10000 - t)
    OP_FACT_DIV  // * reciprocal
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [UnitW-1:0] unit;
    logic [PosW-1:0]  pos;
    logic             final_res;
  } dp_cmd_t;

  typedef struct packed {
    logic             sq_done;
    logic [UnitW-1:0] win;
  } dp_sts_t;
endpackage
`default_nettype wire

// ===== rtl/core/cvq_datapath.sv =====
`default_nettype none
module cvq_datapath
  import cvq_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire dp_cmd_t                cmd,
  output dp_sts_t                     sts,
  input  wire logic signed [15:0]     in_value,
  input  wire logic [15:0]            learning_rate,
  input  wire logic [13:0]            iteration,
  output logic                        out_valid,
  output logic [UnitW-1:0]            out_unit_index,
  output logic [DistW-1:0]            out_distance,
  output logic [UnitW-1:0]            out_winner,
  output logic                        out_final_res
);
  logic signed [15:0] wmem [NumUnits*VectorLen];
  logic signed [15:0] pbuf [VectorLen];
  logic [SumW-1:0]    sums [NumUnits];

  logic signed [15:0] xin_r;
  logic signed [15:0] wrd_r;
  logic signed [15:0] xrd_r;
  logic [SumW-1:0]    best_r;
  logic [UnitW-1:0]   win_r;
  logic [SumW-1:0]    sq_v_r;
  logic [DistW-1:0]   sq_res;
  logic [SumW+1:0]    sq_bit_r;
  logic [SumW+1:0]    sq_acc_r;
  logic signed [33:0] prod_r;
  logic [29:0]        fraw_r;
  logic [15:0]        fact_r;
  logic               valid_r;
  logic [UnitW-1:0]   oidx_r;
  logic [DistW-1:0]   odist_r;
  logic               ofin_r;

  logic [AddrW-1:0]   addr;
  logic signed [16:0] diff;
  logic [33:0]        sq;
  logic [SumW:0]      ssum;
  logic [SumW+1:0]    trial;
  logic [33:0]        mag;
  logic [17:0]        dmag;
  logic signed [18:0] nw;
  logic signed [15:0] nw_sat;
  logic [59:0]        recip;

  assign addr  = {cmd.unit, cmd.pos};
  assign diff  = 17'(xrd_r) - 17'(wrd_r);
  assign sq    = 34'(diff * diff);
  assign ssum  = {1'b0, sums[cmd.unit]} + (SumW+1)'(sq);
  // isqrt step: sq_acc_r holds res, sq_bit_r the bit
  assign trial = sq_acc_r + sq_bit_r;
  assign mag   = prod_r[33] ? 34'(-prod_r) : 34'(prod_r);
  assign dmag  = 18'((mag + 34'd32768) >> 16);
  assign nw    = prod_r[33] ? 19'(wrd_r) - 19'(dmag) : 19'(wrd_r) + 19'(dmag);
  assign nw_sat = (nw > 19'sd32767) ? 16'sh7fff :
                  (nw < -19'sd32768) ? 16'sh8000 : 16'(nw);
  // floor(v/10000), v < 2^30: multiply by ceil(2^43/10000)
  assign recip = 60'(fraw_r) * 60'd879609303;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) wmem[addr] <= in_value;
    if (cmd.op == OP_TR_WR) wmem[addr] <= nw_sat;
    if (cmd.op == OP_ACC_RD || cmd.op == OP_TR_RD) wrd_r <= wmem[addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_CAPT) xin_r <= in_value;
    if (cmd.op == OP_ACC_RD && cmd.unit == '0) pbuf[cmd.pos] <= xin_r;
    if (cmd.op == OP_ACC_RD) xrd_r <= xin_r;
    if (cmd.op == OP_TR_RD) xrd_r <= pbuf[cmd.pos];
    if (cmd.op == OP_TR_MUL) prod_r <= 34'(fact_r) * 34'(diff);
    if (cmd.op == OP_FACT_MUL)
      fraw_r <= 30'(learning_rate) *
                30'(14'd10000 - ((iteration > 14'd10000) ? 14'd10000 : iteration));
    if (cmd.op == OP_FACT_DIV) fact_r <= 16'(recip >> 43);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumUnits; i++) sums[i] <= '0;
    end else if (cmd.op == OP_CLEAR) begin
      for (int i = 0; i < NumUnits; i++) sums[i] <= '0;
    end else if (cmd.op == OP_ACC_ADD) begin
      sums[cmd.unit] <= ssum[SumW] ? SumMax :
                        ((ssum[SumW-1:0] > SumMax) ? SumMax : ssum[SumW-1:0]);
    end
  end

  // winner search
  always_ff @(posedge clk) begin
    if (cmd.op == OP_SRCH) begin
      if (cmd.unit == '0 || sums[cmd.unit] < best_r) begin
        best_r <= sums[cmd.unit];
        win_r  <= cmd.unit;
      end
    end
  end

  // bit-serial isqrt, two bits of input a step
  always_ff @(posedge clk) begin
    if (cmd.op == OP_SQ_INIT) begin
      sq_v_r   <= sums[cmd.unit];
      sq_acc_r <= '0;
      sq_bit_r <= (SumW+2)'(1) << 38;
    end else if (cmd.op == OP_SQ_STEP && sq_bit_r != '0) begin
      if ((SumW+2)'(sq_v_r) >= trial) begin
        sq_v_r   <= SumW'((SumW+2)'(sq_v_r) - trial);
        sq_acc_r <= (sq_acc_r >> 1) + sq_bit_r;
      end else begin
        sq_acc_r <= sq_acc_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
    end
  end
  assign sq_res = (sq_acc_r > (SumW+2)'(DistMax)) ? DistMax : DistW'(sq_acc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= (cmd.op == OP_EMIT);
    if (cmd.op == OP_EMIT) begin
      oidx_r  <= cmd.unit;
      odist_r <= sq_res;
      ofin_r  <= cmd.final_res;
    end
  end

  assign sts.sq_done      = (sq_bit_r == '0);
  assign sts.win          = win_r;
  assign out_valid        = valid_r;
  assign out_unit_index   = oidx_r;
  assign out_distance     = odist_r;
  assign out_winner       = win_r;
  assign out_final_res    = ofin_r;
endmodule
`default_nettype wire

// ===== rtl/core/cvq_ctrl.sv =====
`default_nettype none
module cvq_ctrl
  import cvq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       in_cmd,
  input  wire logic [UnitW-1:0] in_unit,
  input  wire logic [PosW-1:0]  in_position,
  input  wire logic             in_last,
  input  wire logic [CntW-1:0]  units_used,
  output dp_cmd_t               cmd,
  input  wire dp_sts_t          sts
);
  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_ADD, S_SRCH, S_SQI, S_SQS, S_EMIT,
    S_F1, S_F2, S_TRD, S_TMUL, S_TWR, S_CLR
  } state_t;

  state_t           state_r;
  logic             train_r;
  logic             last_r;
  logic [UnitW-1:0] u_r;
  logic [PosW-1:0]  p_r;
  logic [CntW-1:0]  cnt_r;
  logic [UnitW-1:0] n_last;
  logic             accepted;

  assign n_last = (units_used == '0) ? '0 :
                  (units_used > CntW'(NumUnits)) ? UnitW'(NumUnits-1) :
                  UnitW'(units_used - 1'b1);
  assign accepted = start && (state_r == S_IDLE);
  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      u_r     <= '0;
      p_r     <= '0;
      train_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accepted && (in_cmd == CMD_TRAIN || in_cmd == CMD_CLASSIFY)) begin
            train_r <= (in_cmd == CMD_TRAIN);
            last_r  <= in_last;
            u_r     <= '0;
            p_r     <= PosW'(cnt_r);
            if (cnt_r < CntW'(VectorLen)) state_r <= S_RD;
            else if (in_last) state_r <= S_SRCH;
          end
        end
        S_RD: state_r <= S_ADD;
        S_ADD: begin
          if (u_r == UnitW'(NumUnits-1)) begin
            cnt_r <= cnt_r + 1'b1;
            u_r   <= '0;
            state_r <= last_r ? S_SRCH : S_IDLE;
          end else begin
            u_r <= u_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_SRCH: begin
          if (u_r == n_last) begin
            u_r <= '0;
            state_r <= S_SQI;
          end else u_r <= u_r + 1'b1;
        end
        S_SQI: state_r <= S_SQS;
        S_SQS: if (sts.sq_done) state_r <= S_EMIT;
        S_EMIT: begin
          if (train_r) begin
            p_r <= '0;
            state_r <= (cnt_r == '0) ? S_CLR : S_F1;
          end else if (u_r == n_last) state_r <= S_CLR;
          else begin
            u_r <= u_r + 1'b1;
            state_r <= S_SQI;
          end
        end
        S_F1: state_r <= S_F2;
        S_F2: state_r <= S_TRD;
        S_TRD: state_r <= S_TMUL;
        S_TMUL: state_r <= S_TWR;
        S_TWR: begin
          if (CntW'(p_r) + 1'b1 >= cnt_r) state_r <= S_CLR;
          else begin
            p_r <= p_r + 1'b1;
            state_r <= S_TRD;
          end
        end
        S_CLR: begin
          cnt_r <= '0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '{op: OP_NONE, unit: u_r, pos: p_r, final_res: 1'b0};
    unique case (state_r)
      S_IDLE: begin
        if (accepted && in_cmd == CMD_LOAD) begin
          cmd.op = OP_LOAD; cmd.unit = in_unit; cmd.pos = in_position;
        end else if (accepted && (in_cmd == CMD_TRAIN || in_cmd == CMD_CLASSIFY)) begin
          cmd.op = OP_CAPT;
        end
      end
      S_RD:   cmd.op = OP_ACC_RD;
      S_ADD:  cmd.op = OP_ACC_ADD;
      S_SRCH: cmd.op = OP_SRCH;
      S_SQI: begin
        cmd.op = OP_SQ_INIT;
        if (train_r) cmd.unit = sts.win;
      end
      S_SQS:  cmd.op = OP_SQ_STEP;
      S_EMIT: begin
        cmd.op = OP_EMIT;
        if (train_r) cmd.unit = sts.win;
        cmd.final_res = train_r || (u_r == n_last);
      end
      S_F1:   cmd.op = OP_FACT_MUL;
      S_F2:   cmd.op = OP_FACT_DIV;
      S_TRD:  begin cmd.op = OP_TR_RD;  cmd.unit = sts.win; end
      S_TMUL: begin cmd.op = OP_TR_MUL; cmd.unit = sts.win; end
      S_TWR:  begin cmd.op = OP_TR_WR;  cmd.unit = sts.win; end
      S_CLR:  cmd.op = OP_CLEAR;
      default: cmd.op = OP_NONE;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/core/competitive_vq_trainer_unit.sv =====
// Channel  | Ports                                          | Handshake
// input    | in_cmd in_unit in_position in_value in_last    | start & !busy
// result   | out_unit_index out_distance out_winner out_final_res | out_valid, 1 cycle
// config   | cfg_we cfg_index cfg_data                      | cfg_we, immediate
//
// Weight load: written in the accept cycle, busy stays low. Pattern element:
// busy for a weight RAM read, then an add, for each of the 16 units, in use
// or not; the weight RAM has a single port.
// Last element adds a winner scan over the units in use, then per reported
// unit a square root (load, steps) and an emit; train adds the rate factor
// and a read, multiply, write back per element; then the sums are cleared.
// Reset (rst_n low, synchronous) clears sums, counts and control; weights
// stay undefined until loaded. The receiver cannot stall: each transfer
// is on the out_ ports for exactly one cycle.
`default_nettype none
module competitive_vq_trainer_unit
  import cvq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_cmd,
  input  wire logic [UnitW-1:0]  in_unit,
  input  wire logic [PosW-1:0]   in_position,
  input  wire logic signed [15:0] in_value,
  input  wire logic              in_last,
  output logic                   out_valid,
  output logic [UnitW-1:0]       out_unit_index,
  output logic [DistW-1:0]       out_distance,
  output logic [UnitW-1:0]       out_winner,
  output logic                   out_final_res,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [15:0]       cfg_data
);
  logic [15:0]     rate_r;
  logic [13:0]     iter_r;
  logic [CntW-1:0] units_r;
  dp_cmd_t         dcmd;
  dp_sts_t         dsts;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= 16'd13107;
      iter_r  <= 14'd1;
      units_r <= CntW'(NumUnits);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RATE:  rate_r  <= cfg_data;
        REG_ITER:  iter_r  <= cfg_data[13:0];
        REG_UNITS: units_r <= cfg_data[CntW-1:0];
        default: ;
      endcase
    end
  end

  cvq_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy, .in_cmd, .in_unit, .in_position, .in_last,
    .units_used(units_r), .cmd(dcmd), .sts(dsts)
  );

  cvq_datapath u_dp (
    .clk, .rst_n, .cmd(dcmd), .sts(dsts), .in_value,
    .learning_rate(rate_r), .iteration(iter_r),
    .out_valid, .out_unit_index, .out_distance, .out_winner, .out_final_res
  );

  // no transfer while idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |=> !out_valid) else $error("result while idle");
  // results only come while a pattern is still being finished
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result without busy");
  // the final result is not followed straight by another
  a_final_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_final_res |=> !out_valid) else $error("extra result");
endmodule
`default_nettype wire
